[rtl/core/wskd_pkg.sv]
// shared types, constants and microcode program for the key number decoder
package wskd_pkg;

	// character codes
	localparam logic [7:0] SPACE_CHAR = 8'h20;
	localparam logic [7:0] DIGIT_LO   = 8'h30;
	localparam logic [7:0] DIGIT_HI   = 8'h39;

	// field and state widths
	localparam int unsigned NUM_W   = 32;
	localparam int unsigned SPACE_W = 9;
	localparam int unsigned ACC_W   = NUM_W + 4;
	localparam int unsigned DIV_CNT_W = $clog2(NUM_W);

	localparam logic [SPACE_W-1:0] SPACE_MAX = '1;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NO_SPACES = 2'd1;
	localparam logic [1:0] ST_NO_DIGITS = 2'd2;
	localparam logic [1:0] ST_OVERFLOW  = 2'd3;

	// microcode step addresses
	typedef logic [2:0] step_t;
	localparam step_t STEP_TAKE   = 3'd0;
	localparam step_t STEP_CHECK  = 3'd1;
	localparam step_t STEP_START  = 3'd2;
	localparam step_t STEP_DIVIDE = 3'd3;
	localparam step_t STEP_EMIT   = 3'd4;

	// jump conditions
	typedef enum logic [2:0] {
		COND_ALWAYS,
		COND_LAST_TAKEN,
		COND_FAULT,
		COND_DIV_IDLE,
		COND_OUT_FREE
	} cond_t;

	// one control word
	typedef struct packed {
		logic  take;
		logic  div_start;
		logic  emit;
		cond_t cond;
		step_t on_true;
		step_t on_false;
	} ucode_t;

	// divider status seen by the sequencer
	typedef struct packed {
		logic busy;
	} div_stat_t;

	// microcode program
	function automatic ucode_t ucode_rom(input step_t step);
		ucode_t w;
		w = '{take: 1'b0, div_start: 1'b0, emit: 1'b0, cond: COND_ALWAYS,
			on_true: STEP_TAKE, on_false: STEP_TAKE};
		case (step)
			STEP_TAKE: begin
				w.take     = 1'b1;
				w.cond     = COND_LAST_TAKEN;
				w.on_true  = STEP_CHECK;
				w.on_false = STEP_TAKE;
			end
			STEP_CHECK: begin
				w.cond     = COND_FAULT;
				w.on_true  = STEP_EMIT;
				w.on_false = STEP_START;
			end
			STEP_START: begin
				w.div_start = 1'b1;
				w.cond      = COND_ALWAYS;
				w.on_true   = STEP_DIVIDE;
				w.on_false  = STEP_DIVIDE;
			end
			STEP_DIVIDE: begin
				w.cond     = COND_DIV_IDLE;
				w.on_true  = STEP_EMIT;
				w.on_false = STEP_DIVIDE;
			end
			STEP_EMIT: begin
				w.emit     = 1'b1;
				w.cond     = COND_OUT_FREE;
				w.on_true  = STEP_TAKE;
				w.on_false = STEP_EMIT;
			end
			default: begin
				w.cond    = COND_ALWAYS;
				w.on_true = STEP_TAKE;
			end
		endcase
		return w;
	endfunction

endpackage

[rtl/core/websocket_key_number_decoder_top.sv]
// top level: microcoded key number decoder with character datapath and output register
//
//  channel | signals                                | direction  | moves
//  --------+----------------------------------------+------------+-----------------------
//  in      | in_valid in_stall key_char last_char   | to block   | one key character
//  out     | out_valid out_stall key_number status  | from block | one decoded key number
//
// characters are taken one per cycle while the sequencer sits on its take step
// a final character is followed by check, start, the divide step (one divider iteration per
// quotient bit, then the idle test) and emit before the next take
// faulted keys skip the divider: check and emit
// the result sits in an output register; emit waits while it holds a stalled result
// reset clears the key state, the sequencer and the output valid
module websocket_key_number_decoder_top #(
	parameter int unsigned MAX_KEY_CHARS = 256
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [7:0]                   key_char,
	input  logic                         last_char,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [wskd_pkg::NUM_W-1:0]   key_number,
	output logic [1:0]                   status
);
	import wskd_pkg::*;

	localparam int unsigned CHAR_CNT_W = $clog2(MAX_KEY_CHARS + 1);

	step_t                  step_q;
	ucode_t                 uc;
	logic                   cond_met;

	logic [NUM_W-1:0]       acc_q;
	logic [SPACE_W-1:0]     spaces_q;
	logic                   digit_seen_q;
	logic                   overflow_q;
	logic [CHAR_CNT_W-1:0]  chars_q;

	logic                   in_take;
	logic                   char_room;
	logic                   is_digit;
	logic [ACC_W-1:0]       acc_next;
	logic [1:0]             key_status;
	logic                   out_free;
	logic                   emit_now;

	div_stat_t              div_stat;
	logic [NUM_W-1:0]       quotient;

	logic                   out_valid_q;
	logic [NUM_W-1:0]       number_q;
	logic [1:0]             status_q;

	// control word for the current step
	assign uc       = ucode_rom(step_q);
	assign in_stall = ~uc.take;
	assign in_take  = in_valid & uc.take;

	// status checks in conversion order
	always_comb begin
		if (!digit_seen_q)
			key_status = ST_NO_DIGITS;
		else if (overflow_q)
			key_status = ST_OVERFLOW;
		else if (spaces_q == '0)
			key_status = ST_NO_SPACES;
		else
			key_status = ST_OK;
	end

	assign out_free = ~out_valid_q | ~out_stall;
	assign emit_now = uc.emit & out_free;

	// jump condition select
	always_comb begin
		case (uc.cond)
			COND_ALWAYS:     cond_met = 1'b1;
			COND_LAST_TAKEN: cond_met = in_take & last_char;
			COND_FAULT:      cond_met = key_status != ST_OK;
			COND_DIV_IDLE:   cond_met = ~div_stat.busy;
			COND_OUT_FREE:   cond_met = out_free;
			default:         cond_met = 1'b1;
		endcase
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			step_q <= STEP_TAKE;
		else
			step_q <= cond_met ? uc.on_true : uc.on_false;
	end

	// character classification and decimal accumulate
	assign char_room = chars_q < CHAR_CNT_W'(MAX_KEY_CHARS);
	assign is_digit  = (key_char >= DIGIT_LO) && (key_char <= DIGIT_HI);
	assign acc_next  = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ ACC_W'(key_char - DIGIT_LO);

	// key state, cleared when the result is emitted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q        <= '0;
			spaces_q     <= '0;
			digit_seen_q <= 1'b0;
			overflow_q   <= 1'b0;
			chars_q      <= '0;
		end else if (emit_now) begin
			acc_q        <= '0;
			spaces_q     <= '0;
			digit_seen_q <= 1'b0;
			overflow_q   <= 1'b0;
			chars_q      <= '0;
		end else if (in_take && char_room) begin
			chars_q <= chars_q + 1'b1;
			if (is_digit) begin
				digit_seen_q <= 1'b1;
				if (!overflow_q) begin
					if (acc_next[ACC_W-1:NUM_W] != '0)
						overflow_q <= 1'b1;
					else
						acc_q <= acc_next[NUM_W-1:0];
				end
			end else if (key_char == SPACE_CHAR) begin
				if (spaces_q != SPACE_MAX)
					spaces_q <= spaces_q + 1'b1;
			end
		end
	end

	// divide by the space count
	wskd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (uc.div_start),
		.dividend (acc_q),
		.divisor  (spaces_q),
		.stat     (div_stat),
		.quotient (quotient)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (emit_now)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (emit_now) begin
			number_q <= (key_status == ST_OK) ? quotient : '0;
			status_q <= key_status;
		end
	end

	assign out_valid  = out_valid_q;
	assign key_number = number_q;
	assign status     = status_q;

endmodule

[rtl/core/wskd_div.sv]
// iterative restoring divider, one quotient bit per cycle while busy
module wskd_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [wskd_pkg::NUM_W-1:0]    dividend,
	input  logic [wskd_pkg::SPACE_W-1:0]  divisor,
	output wskd_pkg::div_stat_t           stat,
	output logic [wskd_pkg::NUM_W-1:0]    quotient
);
	import wskd_pkg::*;

	logic                 busy_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [NUM_W-1:0]     quo_q;
	logic [SPACE_W-1:0]   rem_q;
	logic [SPACE_W:0]     shifted;
	logic [SPACE_W+1:0]   trial;
	logic                 fits;

	// one trial subtraction
	assign shifted = {rem_q, quo_q[NUM_W-1]};
	assign trial   = {1'b0, shifted} - {2'b00, divisor};
	assign fits    = ~trial[SPACE_W+1];

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= '0;
		end else if (busy_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == DIV_CNT_W'(NUM_W - 1))
				busy_q <= 1'b0;
		end
	end

	// dividend shifts out while quotient bits shift in
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= {quo_q[NUM_W-2:0], fits};
			rem_q <= fits ? trial[SPACE_W-1:0] : shifted[SPACE_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign quotient  = quo_q;

endmodule

[rtl/core/wskd_checker.sv]
// port-level checker for the key number decoder, bound to the top level
module wskd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic                        last_char,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [wskd_pkg::NUM_W-1:0]  key_number,
	input logic [1:0]                  status
);
	import wskd_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(key_number) && $stable(status))
		else $error("stalled result changed");

	// a faulted key reports a zero number
	a_fault_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_OK |-> key_number == '0)
		else $error("nonzero number with fault status");

	// the final character of a key starts the result phase
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && last_char |=> in_stall)
		else $error("input taken right after a final character");

	// within a key characters keep flowing
	a_mid_key_open: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !last_char |=> !in_stall)
		else $error("input stalled in the middle of a key");

endmodule

bind websocket_key_number_decoder_top wskd_checker u_wskd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_valid   (in_valid),
	.in_stall   (in_stall),
	.last_char  (last_char),
	.out_valid  (out_valid),
	.out_stall  (out_stall),
	.key_number (key_number),
	.status     (status)
);

[test/tb.sv]
// testbench for the key number decoder: directed and random keys checked against a built-in model
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wskd_pkg::*;

	localparam int unsigned KEY_LIMIT    = 256;
	localparam int unsigned RANDOM_CHARS = 800;

	typedef struct packed {
		logic [NUM_W-1:0] number;
		logic [1:0]       code;
	} key_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_stall;
	logic [7:0]       key_char = 8'h00;
	logic             last_char = 1'b0;
	logic             out_valid;
	logic             out_stall = 1'b0;
	logic [NUM_W-1:0] key_number;
	logic [1:0]       status;

	// model copy of the key state
	logic [NUM_W-1:0]   digit_value = '0;
	logic [SPACE_W-1:0] spaces_seen = '0;
	logic               has_digit = 1'b0;
	logic               too_big = 1'b0;
	int unsigned        key_length = 0;

	key_result_t key_results_due[$];
	int unsigned mismatches = 0;
	int unsigned chars_sent = 0;
	logic        steady = 1'b0;

	always #5 clk = ~clk;

	websocket_key_number_decoder_top #(
		.MAX_KEY_CHARS(KEY_LIMIT)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.key_char(key_char),
		.last_char(last_char),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key_number(key_number),
		.status(status)
	);

	// fold one accepted character into the key state, predict a result on the final one
	task automatic decode_char(input logic [7:0] c, input logic fin);
		logic [ACC_W-1:0] grown;
		key_result_t r;
		if (key_length < KEY_LIMIT) begin
			key_length++;
			if (c >= DIGIT_LO && c <= DIGIT_HI) begin
				has_digit = 1'b1;
				if (!too_big) begin
					grown = {4'd0, digit_value} * 10 + (c - DIGIT_LO);
					// accumulator keeps its last in-range value once the number is too big
					if (grown > {4'd0, {NUM_W{1'b1}}})
						too_big = 1'b1;
					else
						digit_value = grown[NUM_W-1:0];
				end
			end else if (c == SPACE_CHAR && spaces_seen != SPACE_MAX) begin
				spaces_seen++;
			end
		end
		if (fin) begin
			// fault priority: no digits, then overflow, then no spaces
			r.number = '0;
			if (!has_digit)
				r.code = ST_NO_DIGITS;
			else if (too_big)
				r.code = ST_OVERFLOW;
			else if (spaces_seen == 0)
				r.code = ST_NO_SPACES;
			else begin
				r.code = ST_OK;
				r.number = digit_value / spaces_seen;
			end
			key_results_due.push_back(r);
			digit_value = '0;
			spaces_seen = '0;
			has_digit = 1'b0;
			too_big = 1'b0;
			key_length = 0;
		end
	endtask

	// one character transaction with a random idle gap in front, none in steady mode
	task automatic send_char(input logic [7:0] c, input logic fin);
		int unsigned gap;
		gap = steady ? 0 : $urandom_range(0, 4);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		key_char <= c;
		last_char <= fin;
		// inputs only move at rising edges, so the falling edge sees settled values
		@(negedge clk);
		while (in_stall) @(negedge clk);
		decode_char(c, fin);
		chars_sent++;
		@(posedge clk);
	endtask

	// whole key from a text, last flag on its final character
	task automatic send_key(input string s);
		for (int i = 0; i < s.len(); i++)
			send_char(s[i], i == s.len() - 1);
	endtask

	// result side: random stall before each transaction unless steady, compare with the oldest prediction
	initial begin : result_sink
		int unsigned hold;
		key_result_t want;
		wait (arst_n);
		@(posedge clk);
		forever begin
			hold = steady ? 0 : $urandom_range(0, 4);
			if (hold != 0) begin
				out_stall <= 1'b1;
				repeat (hold) @(posedge clk);
			end
			out_stall <= 1'b0;
			@(negedge clk);
			while (!out_valid) @(negedge clk);
			if (key_results_due.size() == 0) begin
				$display("%0t: unexpected result: key_number %0d status %0d",
					$time, key_number, status);
				mismatches++;
			end else begin
				want = key_results_due.pop_front();
				if (key_number !== want.number) begin
					$display("%0t: key_number expected %0d actual %0d",
						$time, want.number, key_number);
					mismatches++;
				end
				if (status !== want.code) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.code, status);
					mismatches++;
				end
			end
			@(posedge clk);
		end
	end

	// valid keys, largest number and truncating division
	task automatic test_plain_keys();
		send_key("4294967295 ");
		send_key("7  ");
	endtask

	// every fault status, single faults and several at once
	task automatic test_fault_status();
		send_key("3");
		send_key(" ");
		send_key("a");
		send_key("4294967296");
	endtask

	// bytes at and next to the digit and space codes, plus both ends of the byte range
	task automatic test_char_extremes();
		logic [7:0] seq [9] = '{8'h00, 8'h2F, 8'h30, 8'h3A, 8'h1F, SPACE_CHAR, 8'h21, 8'hFF,
			DIGIT_HI};
		for (int i = 0; i < 9; i++)
			send_char(seq[i], i == 8);
	endtask

	// keys at and past the character limit; the tail is dropped but still ends the key
	task automatic test_overlong_key();
		int unsigned lens [2] = '{KEY_LIMIT, KEY_LIMIT + 44};
		logic [7:0] c;
		foreach (lens[k]) begin
			for (int unsigned i = 0; i < lens[k]; i++) begin
				if (i < KEY_LIMIT - 3)
					c = "a";
				else if (i == KEY_LIMIT - 3)
					c = SPACE_CHAR;
				else if (i == KEY_LIMIT - 2)
					c = "7";
				else if (i == KEY_LIMIT - 1)
					c = DIGIT_HI;
				else
					c = i[0] ? SPACE_CHAR : "5";
				send_char(c, i == lens[k] - 1);
			end
		end
	endtask

	// random keys: mostly digits and spaces mixed with filler, some pure noise
	task automatic test_random_keys();
		int unsigned first, n_dig, n_sp, n_fill, left, pick, len;
		logic [7:0] c;
		first = chars_sent;
		while (chars_sent - first < RANDOM_CHARS) begin
			steady = ($urandom_range(0, 3) == 0);
			if ($urandom_range(0, 4) != 0) begin
				n_dig = $urandom_range(1, 10);
				n_sp = $urandom_range(1, 12);
				n_fill = $urandom_range(0, 6);
				left = n_dig + n_sp + n_fill;
				while (left != 0) begin
					pick = $urandom_range(0, left - 1);
					if (pick < n_dig) begin
						c = DIGIT_LO + 8'($urandom_range(0, 9));
						n_dig--;
					end else if (pick < n_dig + n_sp) begin
						c = SPACE_CHAR;
						n_sp--;
					end else begin
						c = 8'($urandom_range(0, 255));
						n_fill--;
					end
					left--;
					send_char(c, left == 0);
				end
			end else begin
				len = $urandom_range(1, 16);
				for (int unsigned i = 0; i < len; i++)
					send_char(8'($urandom_range(0, 255)), i == len - 1);
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_plain_keys();
		test_fault_status();
		test_char_extremes();
		test_overlong_key();
		test_random_keys();
		in_valid <= 1'b0;
		while (key_results_due.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (mismatches == 0 && key_results_due.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// run limit
	initial begin : watchdog
		#(2_000_000);
		$display("simulation failed");
		$finish;
	end

endmodule

[sim.f]
rtl/core/wskd_pkg.sv
rtl/core/wskd_div.sv
rtl/core/websocket_key_number_decoder_top.sv
rtl/core/wskd_checker.sv
test/tb.sv
